### design/pdf_pkg.sv
package pdf_pkg;

	localparam int COORD_BITS_DEF  = 24;
	localparam int LENGTH_BITS_DEF = 40;
	localparam int QUEUE_DEPTH     = 4;
	localparam int DEGREE_BITS     = 8;

	typedef struct packed {
		logic first_pt;
		logic last_pt;
		logic deg_keep;
	} pdf_flags_t;

	localparam int FLAG_BITS = $bits(pdf_flags_t);

endpackage

### design/pdf_queue.sv
module pdf_queue
	import pdf_pkg::*;
#(
	parameter int WIDTH = 51
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full      = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("push into full queue");
`endif

endmodule

### design/pdf_front.sv
module pdf_front
	import pdf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  x_coord,
	input  logic signed [COORD_BITS-1:0]  y_coord,
	input  logic                          first_point,
	input  logic                          last_point,
	input  logic [DEGREE_BITS-1:0]        start_degree,
	input  logic [DEGREE_BITS-1:0]        end_degree,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [2*COORD_BITS+FLAG_BITS-1:0] q_data
);

	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	logic [COORD_BITS:0]   diff_x;
	logic [COORD_BITS:0]   diff_y;
	logic [COORD_BITS:0]   abs_x;
	logic [COORD_BITS:0]   abs_y;
	pdf_flags_t            flags;

	assign in_stall = q_full;
	assign q_push   = in_valid && !in_stall;

	assign diff_x = {x_coord[COORD_BITS-1], x_coord} - {prev_x_q[COORD_BITS-1], prev_x_q};
	assign diff_y = {y_coord[COORD_BITS-1], y_coord} - {prev_y_q[COORD_BITS-1], prev_y_q};
	assign abs_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
	assign abs_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

	always_comb begin
		flags.first_pt = first_point;
		flags.last_pt  = last_point;
		flags.deg_keep = (start_degree > DEGREE_BITS'(1)) && (end_degree > DEGREE_BITS'(1));
	end

	assign q_data = {flags, abs_x[COORD_BITS-1:0], abs_y[COORD_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (q_push) begin
			prev_x_q <= x_coord;
			prev_y_q <= y_coord;
		end
	end

endmodule

### design/pdf_back.sv
module pdf_back
	import pdf_pkg::*;
#(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [LENGTH_BITS-1:0]        cfg_wdata,
	input  logic                          q_empty,
	input  logic [2*COORD_BITS+FLAG_BITS-1:0] q_data,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          keep,
	output logic [LENGTH_BITS-1:0]        total_length
);

	localparam int NP       = COORD_BITS + 1;
	localparam int PW       = 2 * NP;
	localparam int RW       = COORD_BITS + 3;
	localparam int CW       = $clog2(NP);
	localparam int SQ_BITS  = 2 * COORD_BITS;
	localparam int SEG_BITS = COORD_BITS + 1;
	localparam int EW       = ((LENGTH_BITS > SEG_BITS) ? LENGTH_BITS : SEG_BITS) + 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQX  = 6'b000010,
		ST_SQY  = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_ROOT = 6'b010000,
		ST_ACC  = 6'b100000
	} back_state_t;

	back_state_t            state_q;
	pdf_flags_t             flags_q;
	logic [COORD_BITS-1:0]  dx_q;
	logic [COORD_BITS-1:0]  dy_q;
	logic [SQ_BITS-1:0]     sqx_q;
	logic [SQ_BITS-1:0]     sqy_q;
	logic [PW-1:0]          sh_q;
	logic [RW-1:0]          rem_q;
	logic [SEG_BITS-1:0]    root_q;
	logic [CW-1:0]          cnt_q;
	logic [LENGTH_BITS-1:0] sum_q;
	logic [LENGTH_BITS-1:0] max_len_q;
	logic                   out_valid_q;
	logic                   keep_q;
	logic [LENGTH_BITS-1:0] total_q;

	logic [COORD_BITS-1:0]  mult_in;
	logic [SQ_BITS-1:0]     prod;
	logic [RW-1:0]          rem_cat;
	logic [RW-1:0]          trial;
	logic                   take;
	logic [EW-1:0]          sum_ext;
	logic [EW-1:0]          lmax_ext;
	logic [LENGTH_BITS-1:0] new_sum;
	logic                   new_keep;
	logic                   acc_fire;
	pdf_flags_t             head_flags;

	assign head_flags = pdf_flags_t'(q_data[2*COORD_BITS +: FLAG_BITS]);
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;

	assign mult_in = (state_q == ST_SQX) ? dx_q : dy_q;
	assign prod    = SQ_BITS'(mult_in) * SQ_BITS'(mult_in);

	assign rem_cat = {rem_q[RW-3:0], sh_q[PW-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign take    = (rem_cat >= trial);

	assign sum_ext  = EW'(sum_q) + EW'(root_q);
	assign lmax_ext = EW'({LENGTH_BITS{1'b1}});

	always_comb begin
		if (flags_q.first_pt) begin
			new_sum = '0;
		end else if (sum_ext > lmax_ext) begin
			new_sum = '1;
		end else begin
			new_sum = sum_ext[LENGTH_BITS-1:0];
		end
		new_keep = flags_q.deg_keep || ((max_len_q != '0) && (new_sum > max_len_q));
	end

	assign acc_fire = (state_q == ST_ACC) &&
		(!flags_q.last_pt || !out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					flags_q <= head_flags;
					dx_q    <= q_data[COORD_BITS +: COORD_BITS];
					dy_q    <= q_data[0 +: COORD_BITS];
				end
			end
			ST_SQX: begin
				sqx_q <= prod;
			end
			ST_SQY: begin
				sqy_q <= prod;
			end
			ST_SUM: begin
				sh_q   <= PW'(sqx_q) + PW'(sqy_q);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			ST_ROOT: begin
				sh_q  <= sh_q << 2;
				cnt_q <= cnt_q + 1'b1;
				if (take) begin
					rem_q  <= rem_cat - trial;
					root_q <= {root_q[SEG_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= rem_cat;
					root_q <= {root_q[SEG_BITS-2:0], 1'b0};
				end
			end
			ST_ACC: begin
				if (acc_fire && flags_q.last_pt) begin
					keep_q  <= new_keep;
					total_q <= new_sum;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			max_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (acc_fire && flags_q.last_pt) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= head_flags.first_pt ? ST_ACC : ST_SQX;
					end
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (cnt_q == CW'(NP - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (acc_fire) begin
						sum_q   <= new_sum;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign keep         = keep_q;
	assign total_length = total_q;

`ifndef SYNTH
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_fire && flags_q.first_pt) |=> (sum_q == '0))
		else $error("first vertex did not clear the length");
	a_sum_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_fire && !flags_q.first_pt) |=> (sum_q >= $past(sum_q)))
		else $error("length decreased within a polyline");
	a_root_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && cnt_q == CW'(NP - 1)) |=> (state_q == ST_ACC))
		else $error("square root did not hand over");
`endif

endmodule

### design/polyline_dangle_filter_top.sv
// channel   dir  handshake             payload
// in        in   in_valid / in_stall   x_coord y_coord first_point last_point
//                                      start_degree end_degree
// out       out  out_valid / out_stall keep total_length
// cfg       in   cfg_we                cfg_wdata (max_length)
//
// A segment vertex is squared, summed and put through the radix-4 square
// root (one bit per cycle), then added; a first vertex is only added.
// The front accepts one item per cycle until the 4-entry queue fills.
// arst_n clears the queue, previous vertex, length sum and max_length.
// out_stall only holds the back end when a new result meets a full output.
module polyline_dangle_filter_top
	import pdf_pkg::*;
#(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [LENGTH_BITS-1:0]       cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         first_point,
	input  logic                         last_point,
	input  logic [DEGREE_BITS-1:0]       start_degree,
	input  logic [DEGREE_BITS-1:0]       end_degree,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         keep,
	output logic [LENGTH_BITS-1:0]       total_length
);

	localparam int QW = 2 * COORD_BITS + FLAG_BITS;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic [QW-1:0] q_in;
	logic [QW-1:0] q_head;

	pdf_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.first_point  (first_point),
		.last_point   (last_point),
		.start_degree (start_degree),
		.end_degree   (end_degree),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	pdf_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head_data (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	pdf_back #(
		.COORD_BITS  (COORD_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_empty      (q_empty),
		.q_data       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.keep         (keep),
		.total_length (total_length)
	);

endmodule

### tb/polyline_dangle_filter_top_tb.sv
`timescale 1ns / 1ps

module polyline_dangle_filter_top_tb;
	import pdf_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int LB = LENGTH_BITS_DEF;
	localparam logic [LB-1:0] LEN_ALL = {LB{1'b1}};
	localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam int CYCLE_LIMIT = 6000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int PHASE_ITEMS = 160;
	localparam int SAT_SEGS = 30;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic signed [CB-1:0]   x;
		logic signed [CB-1:0]   y;
		logic                   first_pt;
		logic                   last_pt;
		logic [DEGREE_BITS-1:0] sdeg;
		logic [DEGREE_BITS-1:0] edeg;
	} vertex_t;

	typedef struct {
		logic          keep;
		logic [LB-1:0] total;
	} line_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [LB-1:0]          cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	logic signed [CB-1:0]   x_coord;
	logic signed [CB-1:0]   y_coord;
	logic                   first_point;
	logic                   last_point;
	logic [DEGREE_BITS-1:0] start_degree;
	logic [DEGREE_BITS-1:0] end_degree;
	logic                   out_valid;
	logic                   out_stall;
	logic                   keep;
	logic [LB-1:0]          total_length;

	vertex_t      pending_vtx[$];
	line_result_t length_expect[$];
	idle_mode_t   idle_mode;

	// predictor state
	logic signed [CB-1:0] vtx_prev_x;
	logic signed [CB-1:0] vtx_prev_y;
	logic [LB-1:0]        run_length;
	logic [LB-1:0]        limit_cfg;

	int err_count;
	int vertex_count;
	int result_count;
	int kept_count;
	int limit_writes;
	int cycle_count;

	polyline_dangle_filter_top #(
		.COORD_BITS(CB),
		.LENGTH_BITS(LB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.first_point(first_point),
		.last_point(last_point),
		.start_degree(start_degree),
		.end_degree(end_degree),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.keep(keep),
		.total_length(total_length)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [LB-1:0] floor_root(input logic [63:0] v);
		logic [LB-1:0] r;
		logic [63:0]   t;
		int            b;
		r = '0;
		for (b = 25; b >= 0; b--) begin
			t = 64'(r) | (64'd1 << b);
			if (t * t <= v) r = t[LB-1:0];
		end
		return r;
	endfunction

	task automatic predict_vertex(input vertex_t v);
		longint        dx;
		longint        dy;
		logic [LB-1:0] seg;
		line_result_t  r;
		if (v.first_pt) begin
			run_length = '0;
		end else begin
			dx = longint'(v.x) - longint'(vtx_prev_x);
			dy = longint'(v.y) - longint'(vtx_prev_y);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			seg = floor_root(64'(dx * dx) + 64'(dy * dy));
			if (seg > LEN_ALL - run_length) run_length = LEN_ALL;
			else run_length = run_length + seg;
		end
		vtx_prev_x = v.x;
		vtx_prev_y = v.y;
		if (v.last_pt) begin
			r.keep = (v.sdeg > 1 && v.edeg > 1) ||
				(limit_cfg != '0 && run_length > limit_cfg);
			r.total = run_length;
			length_expect.push_back(r);
		end
	endtask

	// driver
	always @(posedge clk) begin
		logic    gap;
		vertex_t nv;
		if (in_valid && !in_stall) begin
			vertex_count++;
			predict_vertex('{x_coord, y_coord, first_point, last_point,
				start_degree, end_degree});
		end
		if (!in_valid || !in_stall) begin
			case (idle_mode)
				IDLE_SEND: gap = ($urandom_range(0, 99) < 76);
				IDLE_BOTH: gap = ($urandom_range(0, 99) < 10);
				default:   gap = 1'b0;
			endcase
			if (arst_n && pending_vtx.size() > 0 && !gap) begin
				nv = pending_vtx.pop_front();
				x_coord      <= nv.x;
				y_coord      <= nv.y;
				first_point  <= nv.first_pt;
				last_point   <= nv.last_pt;
				start_degree <= nv.sdeg;
				end_degree   <= nv.edeg;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		line_result_t want;
		if (out_valid && !out_stall) begin
			result_count++;
			if (keep === 1'b1) kept_count++;
			if (length_expect.size() == 0) begin
				$display("%t: unexpected item: keep %b total_length %0d",
					$time, keep, total_length);
				err_count++;
			end else begin
				want = length_expect.pop_front();
				if (keep !== want.keep) begin
					$display("%t: keep mismatch: expected %b actual %b",
						$time, want.keep, keep);
					err_count++;
				end
				if (total_length !== want.total) begin
					$display("%t: total_length mismatch: expected %0d actual %0d",
						$time, want.total, total_length);
					err_count++;
				end
			end
		end
		case (idle_mode)
			IDLE_RECV: out_stall <= ($urandom_range(0, 99) < 76);
			IDLE_BOTH: out_stall <= ($urandom_range(0, 99) < 10);
			default:   out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%t: timeout, %0d items still expected", $time, length_expect.size());
			$display("polyline_dangle_filter_top_tb NOT OK");
			$finish;
		end
	end

	task automatic push_vtx(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
		input logic f, input logic l, input logic [7:0] sd, input logic [7:0] ed);
		vertex_t v;
		v = '{x, y, f, l, sd, ed};
		pending_vtx.push_back(v);
	endtask

	function automatic logic [7:0] rand_degree();
		return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) :
			8'($urandom_range(0, 255));
	endfunction

	function automatic int rand_delta(input int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// one polyline, mostly well formed; some noise with random flags
	task automatic gen_polyline(output int added);
		int                   n;
		int                   k;
		int                   scale;
		int                   span;
		logic signed [CB-1:0] px;
		logic signed [CB-1:0] py;
		if ($urandom_range(0, 99) < 15) begin
			n = $urandom_range(1, 4);
			for (k = 0; k < n; k++)
				push_vtx(CB'($urandom), CB'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), rand_degree(), rand_degree());
		end else begin
			n = $urandom_range(1, 8);
			scale = $urandom_range(0, 2);
			span = (scale == 0) ? 255 : 65535;
			px = CB'($urandom);
			py = CB'($urandom);
			for (k = 0; k < n; k++) begin
				if (k > 0) begin
					if (scale == 2) begin
						px = CB'($urandom);
						py = CB'($urandom);
					end else begin
						px = px + CB'(rand_delta(span));
						py = py + CB'(rand_delta(span));
					end
				end
				push_vtx(px, py, k == 0, k == n - 1, rand_degree(), rand_degree());
			end
		end
		added = n;
	endtask

	task automatic write_limit(input logic [LB-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_cfg = v;
		limit_writes++;
	endtask

	// sender holds until every expected item has come, then the design settles
	task automatic wait_idle();
		@(negedge clk);
		while (pending_vtx.size() != 0 || in_valid || length_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [LB-1:0] phase_limit[8];
		int            p;
		int            k;
		int            added;
		int            goal;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		out_stall    = 1'b0;
		x_coord      = '0;
		y_coord      = '0;
		first_point  = 1'b0;
		last_point   = 1'b0;
		start_degree = '0;
		end_degree   = '0;
		idle_mode    = IDLE_NONE;
		vtx_prev_x   = '0;
		vtx_prev_y   = '0;
		run_length   = '0;
		limit_cfg    = '0;
		err_count    = 0;
		vertex_count = 0;
		result_count = 0;
		kept_count   = 0;
		limit_writes = 0;
		cycle_count  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, length limit off
		write_limit('0);
		push_vtx(300, 400, 1'b0, 1'b0, 0, 0);
		push_vtx(300, 400, 1'b0, 1'b1, 2, 2);
		push_vtx(C_MIN, C_MAX, 1'b1, 1'b1, 0, 255);
		push_vtx(C_MAX, C_MIN, 1'b1, 1'b1, 255, 255);
		push_vtx(C_MIN, C_MIN, 1'b1, 1'b0, 0, 0);
		push_vtx(C_MAX, C_MAX, 1'b0, 1'b1, 1, 2);
		push_vtx(C_MAX, C_MIN, 1'b0, 1'b1, 2, 1);
		push_vtx(0, 0, 1'b1, 1'b0, 0, 0);
		push_vtx(C_MIN, 0, 1'b0, 1'b0, 0, 0);
		push_vtx(C_MIN, C_MAX, 1'b0, 1'b1, 1, 1);
		push_vtx(1, 1, 1'b1, 1'b0, 0, 0);
		push_vtx(2, 2, 1'b0, 1'b1, 2, 2);
		push_vtx(0, 0, 1'b1, 1'b0, 0, 0);
		push_vtx(3, -3, 1'b0, 1'b1, 0, 0);
		wait_idle();

		// directed, smallest nonzero limit
		write_limit(1);
		push_vtx(5, 5, 1'b1, 1'b1, 0, 0);
		push_vtx(0, 0, 1'b1, 1'b0, 0, 0);
		push_vtx(1, 0, 1'b0, 1'b1, 2, 1);
		push_vtx(0, 0, 1'b1, 1'b0, 0, 0);
		push_vtx(1, 1, 1'b0, 1'b1, 0, 0);
		push_vtx(0, 0, 1'b1, 1'b0, 0, 0);
		push_vtx(2, 0, 1'b0, 1'b1, 0, 0);
		wait_idle();

		phase_limit[0] = '0;
		phase_limit[1] = 1;
		phase_limit[2] = LEN_ALL;
		phase_limit[3] = LB'(1) << 16;
		phase_limit[4] = LB'(1) << 20;
		phase_limit[5] = LB'(1) << 24;
		phase_limit[6] = LB'({$urandom, $urandom});
		phase_limit[7] = LB'($urandom_range(256, 1 << 26));
		for (p = 0; p < 8; p++) begin
			write_limit(phase_limit[p]);
			idle_mode = idle_mode_t'(p % 4);
			goal = 0;
			while (goal < PHASE_ITEMS) begin
				gen_polyline(added);
				goal += added;
			end
			wait_idle();
			idle_mode = IDLE_NONE;
		end

		// long line between opposite corners builds a large sum
		write_limit(LEN_ALL);
		push_vtx(C_MIN, C_MIN, 1'b1, 1'b0, 0, 0);
		for (k = 1; k <= SAT_SEGS; k++)
			push_vtx((k % 2) ? C_MAX : C_MIN, (k % 2) ? C_MAX : C_MIN, 1'b0,
				k == SAT_SEGS, 1, 1);
		push_vtx(C_MAX, C_MIN, 1'b0, 1'b1, 2, 2);
		wait_idle();
		write_limit(LEN_ALL - 1);
		push_vtx(C_MAX, C_MIN, 1'b0, 1'b1, 0, 0);
		wait_idle();

		$display("Checked %0d items (%0d kept) from %0d vertices under %0d limit writes,",
			result_count, kept_count, vertex_count, limit_writes);
		$display("covering single-vertex, unstarted and continued lines and corner spans.");
		if (err_count == 0 && length_expect.size() == 0) begin
			$display("polyline_dangle_filter_top_tb OK");
		end else begin
			$display("polyline_dangle_filter_top_tb NOT OK");
		end
		$finish;
	end

endmodule

### filelist.f
design/pdf_pkg.sv
design/pdf_queue.sv
design/pdf_front.sv
design/pdf_back.sv
design/polyline_dangle_filter_top.sv
tb/polyline_dangle_filter_top_tb.sv
